### rtl/msp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator package
// Shared widths, codes, channel control types and the resolution decoder.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int CHANNELS_DEF   = 5;
   localparam int COUNT_BITS_DEF = 16;

   localparam int KIND_W    = 2;
   localparam int MOTOR_W   = 3;
   localparam int STEPS_W   = 16;
   localparam int RES_W     = 5;
   localparam int MODE_W    = 3;
   localparam int TICK_W    = 16;
   localparam int OUT_LANES = 5;

   localparam logic [TICK_W-1:0] TICK_RESET = 16'd2499;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK     = 2'd0,
      KIND_MOVE     = 2'd1,
      KIND_MOVE_RES = 2'd2
   } kind_type;

   localparam logic [RES_W-1:0] RES_NONE  = 5'd0;
   localparam logic [RES_W-1:0] RES_DIV2  = 5'd2;
   localparam logic [RES_W-1:0] RES_DIV4  = 5'd4;
   localparam logic [RES_W-1:0] RES_DIV8  = 5'd8;
   localparam logic [RES_W-1:0] RES_DIV16 = 5'd16;

   localparam logic [MODE_W-1:0] MODE_FULL  = 3'b000;
   localparam logic [MODE_W-1:0] MODE_DIV2  = 3'b001;
   localparam logic [MODE_W-1:0] MODE_DIV4  = 3'b010;
   localparam logic [MODE_W-1:0] MODE_DIV8  = 3'b011;
   localparam logic [MODE_W-1:0] MODE_DIV16 = 3'b111;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [MOTOR_W-1:0] motor;
      logic [STEPS_W-1:0] steps;
      logic               direction;
      logic [RES_W-1:0]   resolution;
   } item_type;

   typedef struct packed {
      logic               load;
      logic               set_res;
      logic               pass;
      logic [STEPS_W-1:0] steps;
      logic               direction;
      logic [RES_W-1:0]   resolution;
   } chan_ctrl_type;

   typedef struct packed {
      logic             step;
      logic             dir_level;
      logic [RES_W-1:0] pending;
      logic             moving;
   } chan_status_type;

   function automatic logic [MODE_W-1:0] decode_resolution(input logic [RES_W-1:0] code);
      logic [MODE_W-1:0] pins;
      unique case (code)
         RES_DIV2:  pins = MODE_DIV2;
         RES_DIV4:  pins = MODE_DIV4;
         RES_DIV8:  pins = MODE_DIV8;
         RES_DIV16: pins = MODE_DIV16;
         default:   pins = MODE_FULL;
      endcase
      return pins;
   endfunction

endpackage

### rtl/msp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator stream interfaces
// Request and response channels with valid, ready and payload.
// ----------------------------------------------------------------------------
interface msp_req_if import msp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [MOTOR_W-1:0] motor;
   logic [STEPS_W-1:0] steps;
   logic               direction;
   logic [RES_W-1:0]   resolution;

   modport source (output valid, kind, motor, steps, direction, resolution, input ready);
   modport sink   (input valid, kind, motor, steps, direction, resolution, output ready);
endinterface

interface msp_rsp_if import msp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [OUT_LANES-1:0] step_pulses;
   logic [OUT_LANES-1:0] direction_levels;
   logic [MODE_W-1:0]    microstep_pins;
   logic [OUT_LANES-1:0] moving;

   modport source (output valid, step_pulses, direction_levels, microstep_pins, moving,
                   input ready);
   modport sink   (input valid, step_pulses, direction_levels, microstep_pins, moving,
                   output ready);
endinterface

### rtl/msp_input_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator input register
// Captures one request item and holds it until the processing stage takes it.
// ----------------------------------------------------------------------------
module msp_input_reg import msp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   msp_req_if.sink     req_bus,
   input  logic        advance,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind       <= req_bus.kind;
         item_ff.motor      <= req_bus.motor;
         item_ff.steps      <= req_bus.steps;
         item_ff.direction  <= req_bus.direction;
         item_ff.resolution <= req_bus.resolution;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/msp_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator channel
// Position, target, direction and pending resolution of one motor channel.
// ----------------------------------------------------------------------------
module msp_channel import msp_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  chan_ctrl_type   ctrl,
   output chan_status_type status
);

   logic [COUNT_BITS-1:0] pos_ff;
   logic [COUNT_BITS-1:0] pos_in;
   logic [COUNT_BITS-1:0] tgt_ff;
   logic [COUNT_BITS-1:0] tgt_in;
   logic                  dir_ff;
   logic                  dir_in;
   logic [RES_W-1:0]      pend_ff;
   logic [RES_W-1:0]      pend_in;
   logic                  step;

   assign step = ctrl.pass && (pos_ff < tgt_ff);

   always_comb begin
      pos_in  = pos_ff;
      tgt_in  = tgt_ff;
      dir_in  = dir_ff;
      pend_in = pend_ff;
      if (ctrl.load) begin
         tgt_in = COUNT_BITS'(ctrl.steps);
         pos_in = '0;
         dir_in = ctrl.direction;
         if (ctrl.set_res) begin
            pend_in = ctrl.resolution;
         end
      end else if (step) begin
         pos_in  = pos_ff + COUNT_BITS'(1);
         pend_in = RES_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         tgt_ff  <= '0;
         dir_ff  <= 1'b1;
         pend_ff <= RES_NONE;
      end else begin
         pos_ff  <= pos_in;
         tgt_ff  <= tgt_in;
         dir_ff  <= dir_in;
         pend_ff <= pend_in;
      end
   end

   assign status.step      = step;
   assign status.dir_level = dir_ff;
   assign status.pending   = pend_ff;
   assign status.moving    = pos_in < tgt_in;

endmodule

### rtl/multi_axis_step_pulse_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-axis step pulse generator
// Timer-driven step and direction generator for several motor channels.
// ----------------------------------------------------------------------------
// A result is valid once its item has passed the input register and the result
// register (the input register takes the item, the result register takes its
// result once the response side can advance).
// Throughput: one item per cycle unless the response stalls; the channel update
// and the divider finish in a single pass. The configuration port is always ready.
// Reset is synchronous and active high; it restores every channel and the
// divider compare value.
module multi_axis_step_pulse_generator_unit import msp_pkg::*; #(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   msp_req_if.sink           req_bus,
   msp_rsp_if.source         rsp_bus,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TICK_W-1:0] csr_data
);

   logic                 in_valid;
   item_type             item;
   logic                 advance;
   logic                 proc;
   logic                 is_tick;
   logic                 is_move;
   logic                 wrap;

   logic [TICK_W-1:0]    divide_ff;
   logic [TICK_W-1:0]    cnt_ff;
   logic [TICK_W-1:0]    cnt_in;
   logic [CHANNELS-1:0]  dir_hold_ff;
   logic [CHANNELS-1:0]  dir_hold_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [MODE_W-1:0]    mode_in;
   logic [CHANNELS-1:0]  pulses;
   logic [CHANNELS-1:0]  moving_vec;

   chan_ctrl_type        ctrl   [CHANNELS];
   chan_status_type      status [CHANNELS];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [OUT_LANES-1:0] pulses_out;
   logic [OUT_LANES-1:0] dir_out;
   logic [OUT_LANES-1:0] moving_out;
   logic [OUT_LANES-1:0] rsp_pulses_ff;
   logic [OUT_LANES-1:0] rsp_dir_ff;
   logic [MODE_W-1:0]    rsp_mode_ff;
   logic [OUT_LANES-1:0] rsp_moving_ff;

   msp_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (in_valid),
      .item       (item)
   );

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign proc    = in_valid && advance;
   assign is_tick = item.kind == KIND_TICK;
   assign is_move = (item.kind == KIND_MOVE) || (item.kind == KIND_MOVE_RES);
   assign wrap    = cnt_ff >= divide_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         divide_ff <= TICK_RESET;
      end else if (csr_valid) begin
         divide_ff <= csr_data;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (proc && is_tick) begin
         cnt_in = wrap ? '0 : cnt_ff + TICK_W'(1);
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign ctrl[i].load       = proc && is_move && (32'(item.motor) == i);
      assign ctrl[i].set_res    = item.kind == KIND_MOVE_RES;
      assign ctrl[i].pass       = proc && is_tick && wrap;
      assign ctrl[i].steps      = item.steps;
      assign ctrl[i].direction  = item.direction;
      assign ctrl[i].resolution = item.resolution;

      msp_channel #(
         .COUNT_BITS (COUNT_BITS)
      ) u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl[i]),
         .status (status[i])
      );

      assign pulses[i]     = status[i].step;
      assign moving_vec[i] = status[i].moving;
   end

   // Scanned upward, so the top stepping channel with a pending code sets mode pins.
   always_comb begin
      dir_hold_in = dir_hold_ff;
      mode_in     = mode_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         if (status[i].step) begin
            dir_hold_in[i] = status[i].dir_level;
            if (status[i].pending != RES_NONE) begin
               mode_in = decode_resolution(status[i].pending);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         dir_hold_ff <= '0;
         mode_ff     <= MODE_FULL;
      end else begin
         cnt_ff      <= cnt_in;
         dir_hold_ff <= dir_hold_in;
         mode_ff     <= mode_in;
      end
   end

   for (genvar o = 0; o < OUT_LANES; o++) begin : g_lane
      if (o < CHANNELS) begin : g_used
         assign pulses_out[o] = pulses[o];
         assign dir_out[o]    = dir_hold_in[o];
         assign moving_out[o] = moving_vec[o];
      end else begin : g_unused
         assign pulses_out[o] = 1'b0;
         assign dir_out[o]    = 1'b0;
         assign moving_out[o] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_pulses_ff <= pulses_out;
         rsp_dir_ff    <= dir_out;
         rsp_mode_ff   <= mode_in;
         rsp_moving_ff <= moving_out;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.step_pulses      = rsp_pulses_ff;
   assign rsp_bus.direction_levels = rsp_dir_ff;
   assign rsp_bus.microstep_pins   = rsp_mode_ff;
   assign rsp_bus.moving           = rsp_moving_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      proc && !is_tick |=> rsp_pulses_ff == '0)
      else $error("Step pulses reported for an item that is not a timer tick.");

   assert property (@(posedge clock) disable iff (reset)
      proc && is_tick && !wrap |=> cnt_ff == TICK_W'($past(cnt_ff) + TICK_W'(1)))
      else $error("Divider did not count up on a tick without a wrap.");

   assert property (@(posedge clock) disable iff (reset)
      !proc |=> cnt_ff == $past(cnt_ff) && mode_ff == $past(mode_ff))
      else $error("Divider or mode pins changed without a processed item.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready && in_valid |-> !req_bus.ready)
      else $error("Request accepted while both stages are full.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid)
      else $error("Valid state survived reset.");
`endif

endmodule

### tb/sv/tb_multi_axis_step_pulse_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-axis step pulse generator testbench
// Sends ticks and move commands through the request channel, tracks the
// channels, the divider and the pins in a local model, and compares every
// response item with the model, or with the hand result of a typed table
// row. The table-driven opening covers the edge cases. Random phases follow
// under several divider settings, with bursts of idling on both channels
// and one long response stall.
module tb_multi_axis_step_pulse_generator_unit;
   import msp_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;
   localparam int ROW_COUNT = 26;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [OUT_LANES-1:0] step_pulses;
      logic [OUT_LANES-1:0] direction_levels;
      logic [MODE_W-1:0]    microstep_pins;
      logic [OUT_LANES-1:0] moving;
   } pin_snapshot_type;

   typedef struct packed {
      logic             typed;
      pin_snapshot_type want;
   } hand_result_type;

   typedef struct packed {
      logic              is_write;
      logic [TICK_W-1:0] divide;
      item_type          stim;
      logic              typed;
      pin_snapshot_type  want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [TICK_W-1:0] csr_data;

   msp_req_if req_bus();
   msp_rsp_if rsp_bus();

   multi_axis_step_pulse_generator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Local copy of the generator state.
   logic [STEPS_W-1:0] pos_count [CHANNELS];
   logic [STEPS_W-1:0] goal_count [CHANNELS];
   logic               dir_cmd [CHANNELS];
   logic [RES_W-1:0]   res_pending [CHANNELS];
   logic [OUT_LANES-1:0] dir_hold;
   logic [MODE_W-1:0]  mode_hold;
   logic [TICK_W-1:0]  tick_count;
   logic [TICK_W-1:0]  divide_cfg;

   pin_snapshot_type expected_pins_q[$];
   hand_result_type  hand_result_q[$];
   directed_row_type directed_rows [ROW_COUNT];

   int  error_count = 0;
   int  cycle_count;
   bit  quiet;
   bit  hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                  cycle_count);
   endtask

   function automatic logic [MODE_W-1:0] mode_for_code(input logic [RES_W-1:0] code);
      case (code)
         RES_DIV2:  return MODE_DIV2;
         RES_DIV4:  return MODE_DIV4;
         RES_DIV8:  return MODE_DIV8;
         RES_DIV16: return MODE_DIV16;
         default:   return MODE_FULL;
      endcase
   endfunction

   function automatic pin_snapshot_type apply_item(input item_type it);
      pin_snapshot_type snap;
      logic [OUT_LANES-1:0] pulses;
      pulses = '0;
      if (it.kind == KIND_TICK) begin
         if (tick_count >= divide_cfg) begin
            tick_count = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               if (pos_count[ch] < goal_count[ch]) begin
                  if (res_pending[ch] != RES_NONE) begin
                     mode_hold = mode_for_code(res_pending[ch]);
                     res_pending[ch] = RES_NONE;
                  end
                  dir_hold[ch] = dir_cmd[ch];
                  pulses[ch] = 1'b1;
                  pos_count[ch] = pos_count[ch] + STEPS_W'(1);
               end
            end
         end else begin
            tick_count = tick_count + TICK_W'(1);
         end
      end else if ((it.kind == KIND_MOVE || it.kind == KIND_MOVE_RES) &&
                   it.motor < CHANNELS) begin
         goal_count[it.motor] = it.steps;
         pos_count[it.motor] = '0;
         dir_cmd[it.motor] = it.direction;
         if (it.kind == KIND_MOVE_RES)
            res_pending[it.motor] = it.resolution;
      end
      snap.step_pulses = pulses;
      snap.direction_levels = dir_hold;
      snap.microstep_pins = mode_hold;
      for (int ch = 0; ch < CHANNELS; ch++)
         snap.moving[ch] = pos_count[ch] < goal_count[ch];
      return snap;
   endfunction

   always @(posedge clock) begin
      pin_snapshot_type predicted;
      pin_snapshot_type want;
      hand_result_type  hand;
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            pos_count[ch] = '0;
            goal_count[ch] = '0;
            dir_cmd[ch] = 1'b1;
            res_pending[ch] = RES_NONE;
         end
         dir_hold = '0;
         mode_hold = MODE_FULL;
         tick_count = '0;
         divide_cfg = TICK_RESET;
      end else begin
         if (csr_valid && csr_ready)
            divide_cfg = csr_data;
         if (req_bus.valid && req_bus.ready) begin
            predicted = apply_item('{req_bus.kind, req_bus.motor, req_bus.steps,
                                     req_bus.direction, req_bus.resolution});
            if (hand_result_q.size() != 0) begin
               hand = hand_result_q.pop_front();
               if (hand.typed)
                  predicted = hand.want;
            end
            expected_pins_q.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pins_q.size() == 0) begin
               report_mismatch("result with no item waiting", 32'(rsp_bus.step_pulses), 0);
            end else begin
               want = expected_pins_q.pop_front();
               if (rsp_bus.step_pulses !== want.step_pulses)
                  report_mismatch("step_pulses", 32'(rsp_bus.step_pulses),
                                  32'(want.step_pulses));
               if (rsp_bus.direction_levels !== want.direction_levels)
                  report_mismatch("direction_levels", 32'(rsp_bus.direction_levels),
                                  32'(want.direction_levels));
               if (rsp_bus.microstep_pins !== want.microstep_pins)
                  report_mismatch("microstep_pins", 32'(rsp_bus.microstep_pins),
                                  32'(want.microstep_pins));
               if (rsp_bus.moving !== want.moving)
                  report_mismatch("moving", 32'(rsp_bus.moving), 32'(want.moving));
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // The response side stalls in short bursts and once for a long stretch.
   initial begin
      int hold_left;
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready = 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
               @(negedge clock);
               hold_left--;
            end
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic send_item(input item_type it, input logic typed,
                            input pin_snapshot_type want);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      hand_result_q.push_back('{typed, want});
      req_bus.kind = it.kind;
      req_bus.motor = it.motor;
      req_bus.steps = it.steps;
      req_bus.direction = it.direction;
      req_bus.resolution = it.resolution;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      while (expected_pins_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_divide(input logic [TICK_W-1:0] value);
      wait_for_drain();
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic item_type random_item();
      item_type it;
      int pick;
      logic [RES_W-1:0] res_codes [5];
      res_codes = '{RES_NONE, RES_DIV2, RES_DIV4, RES_DIV8, RES_DIV16};
      pick = $urandom_range(0, 99);
      it.kind = KIND_W'($urandom_range(0, 3));
      it.motor = MOTOR_W'($urandom_range(0, 7));
      it.steps = STEPS_W'($urandom_range(0, 65535));
      it.direction = 1'($urandom_range(0, 1));
      it.resolution = RES_W'($urandom_range(0, 31));
      if (pick < 55) begin
         it.kind = KIND_TICK;
      end else if (pick < 93) begin
         it.kind = ($urandom_range(0, 1) == 0) ? KIND_MOVE : KIND_MOVE_RES;
         if ($urandom_range(0, 9) != 0)
            it.motor = MOTOR_W'($urandom_range(0, CHANNELS - 1));
         if ($urandom_range(0, 4) != 0)
            it.steps = STEPS_W'($urandom_range(0, 12));
         if ($urandom_range(0, 9) < 7)
            it.resolution = res_codes[$urandom_range(0, 4)];
      end else begin
         it.kind = KIND_UNUSED;
      end
      return it;
   endfunction

   initial begin
      logic [TICK_W-1:0] phase_divide [8];
      int phase_items;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_TICK;
      req_bus.motor = '0;
      req_bus.steps = '0;
      req_bus.direction = 1'b0;
      req_bus.resolution = RES_NONE;
      quiet = 1'b0;
      hold_req = 1'b0;

      directed_rows = '{
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE},
           1'b1, '{5'd0, 5'd0, 3'd0, 5'd0}},
         '{1'b0, 16'd0, '{KIND_MOVE, 3'd0, 16'd3, 1'b0, RES_NONE},
           1'b1, '{5'd0, 5'd0, 3'd0, 5'b00001}},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE},
           1'b1, '{5'd0, 5'd0, 3'd0, 5'b00001}},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE},
           1'b1, '{5'd0, 5'd0, 3'd0, 5'b00001}},
         '{1'b1, 16'd1, '0, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE},
           1'b1, '{5'b00001, 5'd0, 3'd0, 5'b00001}},
         '{1'b1, 16'd0, '0, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd4, 16'hFFFF, 1'b1, RES_DIV16}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd3, 16'd2, 1'b1, RES_DIV2}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd1, 16'd0, 1'b1, RES_DIV8}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd2, 16'd1, 1'b0, 5'd5}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd7, 16'hFFFF, 1'b1, 5'd31}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd4, 16'd1, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE, 3'd5, 16'd10, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd7, 16'hFFFF, 1'b1, 5'd31}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_UNUSED, 3'd2, 16'd100, 1'b1, RES_DIV16}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd0, 16'd1, 1'b1, RES_DIV4}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE_RES, 3'd3, 16'd1, 1'b0, 5'd31}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b1, 16'hFFFF, '0, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_MOVE, 3'd2, 16'h5A5A, 1'b1, RES_NONE}, 1'b0, '0},
         '{1'b0, 16'd0, '{KIND_TICK, 3'd0, 16'd0, 1'b0, RES_NONE}, 1'b0, '0}
      };
      phase_divide = '{16'd0, 16'd1, 16'd3, 16'($urandom_range(0, 15)), 16'd2,
                       16'hFFFF, 16'd0, 16'd7};

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_write)
            write_divide(directed_rows[r].divide);
         else
            send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
      end

      for (int p = 0; p < 8; p++) begin
         write_divide(phase_divide[p]);
         if (p == 7)
            quiet = 1'b1;
         phase_items = (phase_divide[p] == 16'hFFFF) ? 50 : 150;
         for (int n = 0; n < phase_items; n++) begin
            if (p == 1 && n == 40)
               hold_req = 1'b1;
            send_item(random_item(), 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_pins_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
